@@ hw/rtl/eds_pkg.sv @@
// shared types and constants for the entry stream deframer
`timescale 1ns / 1ps

package eds_pkg;

  // header layout, counted in header bytes taken
  localparam logic [2:0] HC_LEN_HI  = 3'd0;
  localparam logic [2:0] HC_LEN_LO  = 3'd1;
  localparam logic [2:0] HC_TYPE_HI = 3'd2;
  localparam logic [2:0] HC_TYPE_LO = 3'd3;
  localparam logic [2:0] HC_PATH    = 3'd4;
  localparam logic [2:0] HDR_BYTES  = 3'd5;

  // width of the reported position field
  localparam int POS_W = 24;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_PATH = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } eds_kind_t;

  // one classified word handed from front to back
  typedef struct packed {
    eds_kind_t   kind;
    logic [7:0]  byte_val;
    logic [15:0] content;
    logic [7:0]  name_len;
    logic        last;
  } eds_entry_t;

endpackage

@@ hw/rtl/entry_stream_deframer.sv @@
// top level of the entry stream deframer
//
// Splits a byte stream of downlink entries into path and data words.
// Input channel (in_*): one entry byte per word with its mode and, in
// streamed mode, an end-of-entry flag. Header bytes are absorbed.
// Output channel (out_*): one word per path or data byte with its kind,
// index or offset, content type, path length and last mark; an entry
// without bytes to carry gives a single end marker word.
// Throughput: one input word per cycle while the queue has room; each
// byte needs only counter updates and compares in the front end.
// The front end writes the queue at the accepting edge; the queue head
// loads the output register, raising out_valid, once that register is
// free or being taken.
// When the receiver stalls, the output register holds its word and the
// queue absorbs up to two more; in_ready drops only when the queue is full.
// Reset (synchronous, rst_n low) clears the entry state, the queue and
// the output valid flag; the next byte is taken as the start of an entry.
// OFFSET_BITS sets the width of the byte counter, which saturates at
// its maximum; position reports its low 24 bits.
`timescale 1ns / 1ps

module entry_stream_deframer #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_value,
  input  logic                      in_mode,
  input  logic                      in_stream_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_byte_out,
  output logic [eds_pkg::POS_W-1:0] out_position,
  output logic [15:0]               out_content_kind,
  output logic [7:0]                out_name_length,
  output logic                      out_last
);
  import eds_pkg::*;

  localparam int ENTRY_W = $bits(eds_entry_t);
  localparam int Q_W     = ENTRY_W + OFFSET_BITS;
  localparam int Q_DEPTH = 2;

  logic                   q_not_full, q_not_empty, q_push, q_pop;
  eds_entry_t             push_entry, head_entry;
  logic [OFFSET_BITS-1:0] push_idx, head_idx;
  logic [Q_W-1:0]         head_data;

  // header parsing and classification
  eds_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .in_stream_end (in_stream_end),
    .q_ready       (q_not_full),
    .push          (q_push),
    .push_entry    (push_entry),
    .push_idx      (push_idx)
  );

  // decoupling queue
  eds_queue #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_entry, push_idx}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (head_data)
  );

  assign head_entry = head_data[Q_W-1:OFFSET_BITS];
  assign head_idx   = head_data[OFFSET_BITS-1:0];

  // output formatting and register
  eds_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_entry          (head_entry),
    .q_idx            (head_idx),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte_out     (out_byte_out),
    .out_position     (out_position),
    .out_content_kind (out_content_kind),
    .out_name_length  (out_name_length),
    .out_last         (out_last)
  );

endmodule

@@ hw/rtl/eds_front.sv @@
// front end: header parsing and classification of each received word
`timescale 1ns / 1ps

module eds_front #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_value,
  input  logic                    in_mode,
  input  logic                    in_stream_end,
  input  logic                    q_ready,
  output logic                    push,
  output eds_pkg::eds_entry_t     push_entry,
  output logic [OFFSET_BITS-1:0]  push_idx
);
  import eds_pkg::*;

  localparam int OB = OFFSET_BITS;

  logic [2:0]    header_count_r, header_count_nxt;
  logic [15:0]   payload_length_r, payload_length_nxt;
  logic [15:0]   content_code_r, content_code_nxt;
  logic [7:0]    path_length_r, path_length_nxt;
  logic [OB-1:0] bytes_seen_r, bytes_seen_nxt;

  logic          accept;
  logic          end_flag;
  logic          in_header;
  logic [2:0]    hc_eff;
  logic [2:0]    hc_inc;
  logic [15:0]   pl_hdr, cc_hdr;
  logic [7:0]    plen_hdr;
  logic          hdr_done;
  logic [OB:0]   seen_inc;
  logic [OB:0]   entry_total;
  logic          pay_last;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign end_flag = in_mode & in_stream_end;
  assign in_header = header_count_r < HDR_BYTES;

  // header field capture; a streamed entry starts at the content type
  always_comb begin
    hc_eff   = (header_count_r == HC_LEN_HI && in_mode) ? HC_TYPE_HI : header_count_r;
    pl_hdr   = payload_length_r;
    cc_hdr   = content_code_r;
    plen_hdr = path_length_r;
    unique case (hc_eff)
      HC_LEN_HI:  pl_hdr = {in_value, 8'h00};
      HC_LEN_LO:  pl_hdr = {payload_length_r[15:8], in_value};
      HC_TYPE_HI: cc_hdr = {in_value, 8'h00};
      HC_TYPE_LO: cc_hdr = {content_code_r[15:8], in_value};
      default:    plen_hdr = in_value;
    endcase
    hc_inc   = hc_eff + 3'd1;
    hdr_done = end_flag ||
               (hc_inc == HDR_BYTES && !in_mode && pl_hdr == 16'd0 && plen_hdr == 8'd0);
  end

  // end of entry for path and data words
  assign seen_inc    = {1'b0, bytes_seen_r} + (OB+1)'(1);
  assign entry_total = (OB+1)'(payload_length_r) + (OB+1)'(path_length_r);
  assign pay_last    = in_mode ? end_flag : (seen_inc >= entry_total);

  // classification and next state
  always_comb begin
    header_count_nxt   = header_count_r;
    payload_length_nxt = payload_length_r;
    content_code_nxt   = content_code_r;
    path_length_nxt    = path_length_r;
    bytes_seen_nxt     = bytes_seen_r;
    push               = 1'b0;
    push_idx           = bytes_seen_r;
    push_entry.kind     = KIND_END;
    push_entry.byte_val = in_value;
    push_entry.content  = content_code_r;
    push_entry.name_len = path_length_r;
    push_entry.last     = 1'b0;
    if (accept) begin
      if (in_header) begin
        header_count_nxt   = hc_inc;
        payload_length_nxt = pl_hdr;
        content_code_nxt   = cc_hdr;
        path_length_nxt    = plen_hdr;
        push_entry.content  = cc_hdr;
        push_entry.name_len = plen_hdr;
        push_entry.byte_val = 8'h00;
        push_entry.last     = 1'b1;
        push_idx            = '0;
        push                = hdr_done;
      end else begin
        push = 1'b1;
        push_entry.kind = (bytes_seen_r < OB'(path_length_r)) ? KIND_PATH : KIND_DATA;
        push_entry.last = pay_last;
        if (!(&bytes_seen_r)) begin
          bytes_seen_nxt = seen_inc[OB-1:0];
        end
      end
      // a completed entry returns everything to the idle header state
      if (push && push_entry.last) begin
        header_count_nxt   = HC_LEN_HI;
        payload_length_nxt = 16'd0;
        content_code_nxt   = 16'd0;
        path_length_nxt    = 8'd0;
        bytes_seen_nxt     = '0;
      end
    end
  end

  // entry state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r   <= HC_LEN_HI;
      payload_length_r <= 16'd0;
      content_code_r   <= 16'd0;
      path_length_r    <= 8'd0;
      bytes_seen_r     <= '0;
    end else begin
      header_count_r   <= header_count_nxt;
      payload_length_r <= payload_length_nxt;
      content_code_r   <= content_code_nxt;
      path_length_r    <= path_length_nxt;
      bytes_seen_r     <= bytes_seen_nxt;
    end
  end

  // header counter never passes the header size
  a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_count_r <= HDR_BYTES)
    else $error("header count out of range");

  // a finished entry leaves the header state cleared
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.last) |=> (header_count_r == HC_LEN_HI && bytes_seen_r == '0))
    else $error("entry state not cleared after last word");

  // words are only pushed while the queue has room
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("push into a full queue");

endmodule

@@ hw/rtl/eds_queue.sv @@
// small queue between the front and back ends
`timescale 1ns / 1ps

module eds_queue #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign not_full  = count_r != CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_data = slots_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // fill count stays within the depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ hw/rtl/eds_back.sv @@
// back end: position formatting and the output register
`timescale 1ns / 1ps

module eds_back #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  eds_pkg::eds_entry_t               q_entry,
  input  logic [OFFSET_BITS-1:0]            q_idx,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_byte_out,
  output logic [eds_pkg::POS_W-1:0]         out_position,
  output logic [15:0]                       out_content_kind,
  output logic [7:0]                        out_name_length,
  output logic                              out_last
);
  import eds_pkg::*;

  localparam int OB   = OFFSET_BITS;
  localparam int WIDE = (OB > POS_W) ? OB : POS_W;

  logic              out_valid_r;
  eds_kind_t         kind_r;
  logic [7:0]        byte_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       content_r;
  logic [7:0]        name_len_r;
  logic              last_r;
  logic [OB-1:0]     pos_ob;
  logic [WIDE-1:0]   pos_wide;

  // load a new word when the output register is free or being taken
  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  // path index, data offset with saturation, or zero for an end marker
  always_comb begin
    case (q_entry.kind)
      KIND_PATH: pos_ob = q_idx;
      KIND_DATA: pos_ob = (&q_idx) ? q_idx : q_idx - OB'(q_entry.name_len);
      default:   pos_ob = '0;
    endcase
    pos_wide = WIDE'(pos_ob);
    pos_nxt  = pos_wide[POS_W-1:0];
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r     <= q_entry.kind;
      byte_r     <= q_entry.byte_val;
      pos_r      <= pos_nxt;
      content_r  <= q_entry.content;
      name_len_r <= q_entry.name_len;
      last_r     <= q_entry.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_byte_out     = byte_r;
  assign out_position     = pos_r;
  assign out_content_kind = content_r;
  assign out_name_length  = name_len_r;
  assign out_last         = last_r;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the entry stream deframer
`timescale 1ns / 1ps

module testbench;
  import eds_pkg::*;

  // narrowest byte counter the block allows
  localparam int OFF_BITS = 16;
  localparam int LIMIT_NS = 40_000_000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    eds_kind_t        kind;
    logic [7:0]       byte_val;
    logic [POS_W-1:0] position;
    logic [15:0]      content;
    logic [7:0]       name_len;
    logic             last;
  } deframed_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_value = 8'h00;
  logic             in_mode = 1'b0;
  logic             in_stream_end = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_kind;
  logic [7:0]       out_byte_out;
  logic [POS_W-1:0] out_position;
  logic [15:0]      out_content_kind;
  logic [7:0]       out_name_length;
  logic             out_last;

  // predicted entry state
  logic [2:0]        hdr_taken = 3'd0;
  logic [15:0]       hdr_dlen = 16'd0;
  logic [15:0]       hdr_ctype = 16'd0;
  logic [7:0]        hdr_plen = 8'd0;
  longint unsigned   bytes_taken = 0;

  deframed_word_t expected_words[$];
  int unsigned    bytes_sent = 0;
  int unsigned    error_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;

  entry_stream_deframer #(
    .OFFSET_BITS(OFF_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_mode         (in_mode),
    .in_stream_end   (in_stream_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte_out    (out_byte_out),
    .out_position    (out_position),
    .out_content_kind(out_content_kind),
    .out_name_length (out_name_length),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("testbench: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // clear the predicted entry state after a word that closes an entry
  function automatic void clear_entry();
    hdr_taken = 3'd0;
    hdr_dlen = 16'd0;
    hdr_ctype = 16'd0;
    hdr_plen = 8'd0;
    bytes_taken = 0;
  endfunction

  // predicts the word (if any) that one accepted byte produces
  function automatic bit deframe_byte(input logic [7:0] v, input logic streamed,
                                      input logic se, output deframed_word_t w);
    logic            stop;
    longint unsigned idx;
    longint unsigned sat_max;
    logic            fin;
    stop = streamed & se;
    sat_max = (longint'(1) << OFF_BITS) - 1;
    w.kind = KIND_END;
    w.byte_val = 8'h00;
    w.position = '0;
    w.last = 1'b0;
    // header bytes are absorbed; streamed entries skip the length
    if (hdr_taken < HDR_BYTES) begin
      if (hdr_taken == HC_LEN_HI && streamed) hdr_taken = HC_TYPE_HI;
      case (hdr_taken)
        HC_LEN_HI:  hdr_dlen = {v, 8'h00};
        HC_LEN_LO:  hdr_dlen[7:0] = v;
        HC_TYPE_HI: hdr_ctype = {v, 8'h00};
        HC_TYPE_LO: hdr_ctype[7:0] = v;
        default:    hdr_plen = v;
      endcase
      hdr_taken = hdr_taken + 3'd1;
      if (stop || (hdr_taken == HDR_BYTES && !streamed && hdr_dlen == 16'd0 &&
                   hdr_plen == 8'd0)) begin
        w.content = hdr_ctype;
        w.name_len = hdr_plen;
        w.last = 1'b1;
        clear_entry();
        return 1'b1;
      end
      return 1'b0;
    end
    // path or data byte
    idx = bytes_taken;
    if (idx < longint'(hdr_plen)) begin
      w.kind = KIND_PATH;
      w.position = idx[POS_W-1:0];
    end else begin
      w.kind = KIND_DATA;
      if (idx >= sat_max) w.position = sat_max[POS_W-1:0];
      else w.position = POS_W'(idx - longint'(hdr_plen));
    end
    if (bytes_taken < sat_max) bytes_taken++;
    if (streamed) fin = stop;
    else fin = (idx + 1) >= (longint'(hdr_dlen) + longint'(hdr_plen));
    w.byte_val = v;
    w.content = hdr_ctype;
    w.name_len = hdr_plen;
    w.last = fin;
    if (fin) clear_entry();
    return 1'b1;
  endfunction

  // send one word, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] v, input logic m, input logic se);
    deframed_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_mode <= m;
    in_stream_end <= se;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (deframe_byte(v, m, se, w)) expected_words.push_back(w);
  endtask

  // receiver stalls and result checking
  always @(posedge clk) begin
    deframed_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d byte %0h", out_kind, out_byte_out));
      end else begin
        e = expected_words.pop_front();
        if (out_kind !== e.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, e.kind));
        if (out_byte_out !== e.byte_val)
          report_mismatch($sformatf("byte %0h, want %0h", out_byte_out, e.byte_val));
        if (out_position !== e.position)
          report_mismatch($sformatf("position %0d, want %0d", out_position, e.position));
        if (out_content_kind !== e.content)
          report_mismatch($sformatf("content %0h, want %0h", out_content_kind, e.content));
        if (out_name_length !== e.name_len)
          report_mismatch($sformatf("path length %0d, want %0d", out_name_length, e.name_len));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, e.last));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hand-picked entries covering every kind of word and entry shape
  task automatic test_directed();
    // length-delimited entry with path and data; stream_end set but ignored
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b0);
    send_byte(8'hCD, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    // empty length-delimited entry
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // path-only entry
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b0);
    // streamed entry with one path and one data byte
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h2F, 1'b1, 1'b0);
    send_byte(8'h55, 1'b1, 1'b1);
    // streamed header cut short on its first byte
    send_byte(8'hC7, 1'b1, 1'b1);
    // streamed entry that ends on its last header byte
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h09, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    // mode changes inside one entry
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h44, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b0);
  endtask

  // mostly well-formed entries with random content, some broken ones and noise
  task automatic test_random();
    int unsigned target;
    int unsigned r;
    int unsigned dlen;
    int unsigned plen;
    int unsigned k;
    logic [15:0] ctype;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      target = bytes_sent + 450;
      while (bytes_sent < target) begin
        r = $urandom_range(99);
        ctype = 16'($urandom);
        plen = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(5);
        if (r < 45) begin
          // length-delimited entry
          dlen = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(8);
          send_byte(8'(dlen >> 8), 1'b0, 1'($urandom));
          send_byte(8'(dlen), 1'b0, 1'($urandom));
          send_byte(ctype[15:8], 1'b0, 1'($urandom));
          send_byte(ctype[7:0], 1'b0, 1'($urandom));
          send_byte(8'(plen), 1'b0, 1'($urandom));
          for (int unsigned i = 0; i < plen + dlen; i++) begin
            send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom));
          end
        end else if (r < 85) begin
          // streamed entry, possibly ending on its header
          k = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, plen + 8);
          send_byte(ctype[15:8], 1'b1, 1'b0);
          send_byte(ctype[7:0], 1'b1, 1'b0);
          send_byte(8'(plen), 1'b1, k == 0);
          for (int unsigned i = 0; i < k; i++) begin
            send_byte(8'($urandom_range(255)), 1'b1, i == k - 1);
          end
        end else if (r < 92) begin
          // streamed header cut short
          send_byte(ctype[15:8], 1'b1, $urandom_range(1) == 0);
          if (hdr_taken != 3'd0) send_byte(ctype[7:0], 1'b1, 1'b1);
        end else begin
          // noise, then a streamed end byte to get back in step
          k = $urandom_range(1, 6);
          for (int unsigned i = 0; i < k; i++) begin
            send_byte(8'($urandom_range(255)), 1'($urandom), 1'($urandom));
          end
          send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/eds_pkg.sv
hw/rtl/eds_front.sv
hw/rtl/eds_queue.sv
hw/rtl/eds_back.sv
hw/rtl/entry_stream_deframer.sv
tb/testbench.sv
